>>> hw/rtl/ntsd_pkg.sv
// Shared types, constants and the EIA code map for the tape stream decoder.
package ntsd_pkg;

   localparam int LINE_MAX = 64;
   localparam int LEN_W    = $clog2(LINE_MAX + 1);
   localparam int ADDR_W   = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;

   localparam logic [7:0] EIA_EOB = 8'h80;
   localparam logic [7:0] EIA_EOR = 8'h0B;
   localparam logic [6:0] ISO_LF  = 7'h0A;
   localparam logic [6:0] ISO_PCT = 7'h25;
   localparam logic [6:0] ISO_CR  = 7'h0D;
   localparam logic [6:0] ISO_NUL = 7'h00;
   localparam logic [6:0] ISO_DEL = 7'h7F;

   localparam logic [2:0] EV_START = 3'd1;
   localparam logic [2:0] EV_END   = 3'd2;
   localparam logic [2:0] EV_OVF   = 3'd3;
   localparam logic [2:0] EV_CHAR  = 3'd4;

   typedef enum logic [1:0] {
      CMD_CHAR = 2'd0,
      CMD_EOB  = 2'd1,
      CMD_MARK = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [6:0]   chr;
   } cmd_type;

   // RS-244 code to ASCII; zero marks an unknown code.
   function automatic logic [6:0] eia_lookup(input logic [7:0] code);
      logic [6:0] c;
      unique case (code)
         8'h20: c = 7'h30;  8'h01: c = 7'h31;  8'h02: c = 7'h32;  8'h13: c = 7'h33;
         8'h04: c = 7'h34;  8'h15: c = 7'h35;  8'h16: c = 7'h36;  8'h07: c = 7'h37;
         8'h08: c = 7'h38;  8'h19: c = 7'h39;
         8'h61: c = 7'h41;  8'h62: c = 7'h42;  8'h73: c = 7'h43;  8'h64: c = 7'h44;
         8'h75: c = 7'h45;  8'h76: c = 7'h46;  8'h67: c = 7'h47;  8'h68: c = 7'h48;
         8'h79: c = 7'h49;
         8'h51: c = 7'h4A;  8'h52: c = 7'h4B;  8'h43: c = 7'h4C;  8'h54: c = 7'h4D;
         8'h45: c = 7'h4E;  8'h46: c = 7'h4F;  8'h57: c = 7'h50;  8'h58: c = 7'h51;
         8'h49: c = 7'h52;
         8'h32: c = 7'h53;  8'h23: c = 7'h54;  8'h34: c = 7'h55;  8'h25: c = 7'h56;
         8'h26: c = 7'h57;  8'h37: c = 7'h58;  8'h38: c = 7'h59;  8'h29: c = 7'h5A;
         8'h10: c = 7'h20;  8'h6B: c = 7'h2E;  8'h40: c = 7'h2D;  8'h70: c = 7'h2B;
         8'h31: c = 7'h2F;  8'h3E: c = 7'h09;
         default: c = 7'h00;
      endcase
      return c;
   endfunction

endpackage

>>> hw/rtl/ntsd_front.sv
// Front end: mode register, byte classifier and a two-entry command queue.
module ntsd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic [7:0]       req_wire_byte,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_code_mode,
   output logic             cmd_valid,
   output ntsd_pkg::cmd_type cmd,
   input  logic             cmd_pop
);
   import ntsd_pkg::*;

   logic          mode_ff, mode_in;
   cmd_type       q_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   cmd_type       cls;
   logic          keep;
   logic          push_en, pop_en;
   logic [6:0]    iso_v;
   logic [6:0]    eia_c;

   assign csr_ready = 1'b1;
   assign req_full  = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      iso_v    = req_wire_byte[6:0];
      eia_c    = eia_lookup(req_wire_byte);
      cls.kind = CMD_CHAR;
      cls.chr  = 7'd0;
      keep     = 1'b0;
      if (mode_ff) begin
         if (req_wire_byte == EIA_EOB) begin
            cls.kind = CMD_EOB;
            keep     = 1'b1;
         end else if (req_wire_byte == EIA_EOR) begin
            cls.kind = CMD_MARK;
            keep     = 1'b1;
         end else begin
            cls.chr = eia_c;
            keep    = (eia_c != 7'd0);
         end
      end else begin
         if (iso_v == ISO_LF) begin
            cls.kind = CMD_EOB;
            keep     = 1'b1;
         end else if (iso_v == ISO_PCT) begin
            cls.kind = CMD_MARK;
            keep     = 1'b1;
         end else begin
            cls.chr = iso_v;
            keep    = (iso_v != ISO_CR) && (iso_v != ISO_NUL) && (iso_v != ISO_DEL);
         end
      end
   end

   // ignored and unknown bytes are accepted but never queued
   assign push_en = req_push && !req_full && keep;
   assign pop_en  = cmd_pop && cmd_valid;

   always_comb begin
      mode_in   = (csr_valid && csr_ready) ? csr_code_mode : mode_ff;
      wr_ptr_in = push_en ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_en ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push_en && !pop_en) begin
         count_in = count_ff + 2'd1;
      end else if (pop_en && !push_en) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         mode_ff   <= mode_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

>>> hw/rtl/ntsd_back.sv
// Back end: line store, block state and the result word register.
module ntsd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  ntsd_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [2:0]       rsp_event_res,
   output logic [6:0]       rsp_char_out,
   output logic             rsp_last
);
   import ntsd_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   state_type         state_ff, state_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  idx_ff, idx_in;
   logic              ovf_ff, ovf_in;
   logic              prog_ff, prog_in;
   logic              data_ok_ff, data_ok_in;
   logic              rd_last_ff, rd_last_in;
   logic [6:0]        rd_data_ff;
   logic [6:0]        store_ff [LINE_MAX];

   logic              out_valid_ff, out_valid_in;
   logic [2:0]        out_ev_ff, out_ev_in;
   logic [6:0]        out_chr_ff, out_chr_in;
   logic              out_last_ff, out_last_in;

   logic              slot_free;
   logic              wr_en, rd_en;
   logic              out_load;

   assign slot_free     = !out_valid_ff || rsp_pop;
   assign rsp_empty     = !out_valid_ff;
   assign rsp_event_res = out_ev_ff;
   assign rsp_char_out  = out_chr_ff;
   assign rsp_last      = out_last_ff;

   always_comb begin
      state_in    = state_ff;
      len_in      = len_ff;
      idx_in      = idx_ff;
      ovf_in      = ovf_ff;
      prog_in     = prog_ff;
      data_ok_in  = data_ok_ff;
      rd_last_in  = rd_last_ff;
      cmd_pop     = 1'b0;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      out_load    = 1'b0;
      out_ev_in   = out_ev_ff;
      out_chr_in  = out_chr_ff;
      out_last_in = out_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.kind)
                  CMD_CHAR: begin
                     cmd_pop = 1'b1;
                     if (!ovf_ff) begin
                        if (len_ff >= LEN_W'(LINE_MAX)) begin
                           ovf_in = 1'b1;
                        end else begin
                           wr_en  = 1'b1;
                           len_in = len_ff + 1'b1;
                        end
                     end
                  end
                  CMD_MARK: begin
                     if (slot_free) begin
                        cmd_pop     = 1'b1;
                        out_load    = 1'b1;
                        out_ev_in   = prog_ff ? EV_END : EV_START;
                        out_chr_in  = 7'd0;
                        out_last_in = 1'b1;
                        prog_in     = !prog_ff;
                        ovf_in      = 1'b0;
                        len_in      = '0;
                     end
                  end
                  CMD_EOB: begin
                     if (ovf_ff) begin
                        if (slot_free) begin
                           cmd_pop     = 1'b1;
                           out_load    = 1'b1;
                           out_ev_in   = EV_OVF;
                           out_chr_in  = 7'd0;
                           out_last_in = 1'b1;
                           ovf_in      = 1'b0;
                           len_in      = '0;
                        end
                     end else begin
                        cmd_pop = 1'b1;
                        if (len_ff != '0) begin
                           idx_in     = '0;
                           data_ok_in = 1'b0;
                           state_in   = ST_EMIT;
                        end
                     end
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_EMIT: begin
            // one store read in flight; next read issues as the held one moves out
            if (data_ok_ff && slot_free) begin
               out_load    = 1'b1;
               out_ev_in   = EV_CHAR;
               out_chr_in  = rd_data_ff;
               out_last_in = rd_last_ff;
               data_ok_in  = 1'b0;
               if (rd_last_ff) begin
                  len_in   = '0;
                  state_in = ST_IDLE;
               end
            end
            if ((idx_ff != len_ff) && (!data_ok_ff || (data_ok_ff && slot_free))) begin
               rd_en      = 1'b1;
               data_ok_in = 1'b1;
               rd_last_in = ((idx_ff + 1'b1) == len_ff);
               idx_in     = idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         idx_ff       <= '0;
         ovf_ff       <= 1'b0;
         prog_ff      <= 1'b0;
         data_ok_ff   <= 1'b0;
         rd_last_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         idx_ff       <= idx_in;
         ovf_ff       <= ovf_in;
         prog_ff      <= prog_in;
         data_ok_ff   <= data_ok_in;
         rd_last_ff   <= rd_last_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ev_ff   <= out_ev_in;
      out_chr_ff  <= out_chr_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[len_ff[ADDR_W-1:0]] <= cmd.chr;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[idx_ff[ADDR_W-1:0]];
      end
   end

endmodule

>>> hw/rtl/nc_tape_stream_decoder_unit.sv
// Top level of the NC tape stream decoder.
// Decodes punched-tape bytes (ISO with parity, or EIA RS-244 when csr_code_mode is 1)
// into program start/end, overflow and line character words. A byte is taken into a
// two-entry command queue; the back end retires a character or marker command as soon
// as it sees it, so bytes are absorbed at one per cycle while the result side keeps up.
// An end-of-block streams the stored line at one character word per cycle while results
// are popped, out of the 64-entry line store (registered read): the back end takes the
// end-of-block, reads the first character, then moves each word out as the next read
// issues. While it is busy the input queue holds at most two bytes. Results wait in a
// single output register; the user must write the mode register via csr_ only while
// the block is idle, and the block itself does not enforce it.
module nc_tape_stream_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_wire_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [2:0] rsp_event_res,
   output logic [6:0] rsp_char_out,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_code_mode
);
   import ntsd_pkg::*;

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   ntsd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_wire_byte (req_wire_byte),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_code_mode (csr_code_mode),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop)
   );

   ntsd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_event_res (rsp_event_res),
      .rsp_char_out  (rsp_char_out),
      .rsp_last      (rsp_last)
   );

endmodule

>>> hw/rtl/ntsd_checker.sv
// Port-level checks for the tape stream decoder, bound to the top level.
module ntsd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [2:0] rsp_event_res,
   input logic [6:0] rsp_char_out,
   input logic       rsp_last
);
   import ntsd_pkg::*;

   // a waiting result word holds until it is popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_event_res)
         && $stable(rsp_char_out) && $stable(rsp_last)))
      else $error("result word changed while waiting");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   a_event_code: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_event_res == EV_CHAR
         || ((rsp_event_res == EV_START || rsp_event_res == EV_END
              || rsp_event_res == EV_OVF) && rsp_char_out == 7'd0)))
      else $error("bad event code or stray character");

   // marker and overflow words are always the only word of their byte
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_event_res != EV_CHAR) |-> rsp_last)
      else $error("non-character word without last");

   a_char_nonzero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_event_res == EV_CHAR) |-> (rsp_char_out != 7'd0))
      else $error("line character is zero");

endmodule

bind nc_tape_stream_decoder_unit ntsd_checker u_ntsd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_full      (req_full),
   .rsp_empty     (rsp_empty),
   .rsp_pop       (rsp_pop),
   .rsp_event_res (rsp_event_res),
   .rsp_char_out  (rsp_char_out),
   .rsp_last      (rsp_last)
);
